// File: rtl/mtc_pkg.sv
`default_nettype none

package mtc_pkg;

    localparam int MASK_W  = 8;
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int OFS_W   = 25;
    localparam int REG_W   = 13;

    typedef enum logic [0:0] {
        CFG_ROW_LENGTH = 1'b0,
        CFG_ROW_TOTAL  = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic             has_index;
        logic [IDX_W-1:0] column_index;
        logic             row_done;
        logic [IDX_W-1:0] row_index;
        logic [CNT_W-1:0] row_count;
        logic [OFS_W-1:0] row_end_offset;
        logic             row_nonempty;
        logic [IDX_W-1:0] row_slot;
        logic             matrix_done;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/mtc_if.sv
`default_nettype none

// Mask byte stream.
interface mtc_in_if;
    import mtc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] mask_value;

    modport source (output valid, output mask_value, input ready);
    modport sink   (input valid, input mask_value, output ready);
endinterface

// CSR index result stream.
interface mtc_out_if;
    import mtc_pkg::*;

    logic             valid;
    logic             ready;
    logic             has_index;
    logic [IDX_W-1:0] column_index;
    logic             row_done;
    logic [IDX_W-1:0] row_index;
    logic [CNT_W-1:0] row_count;
    logic [OFS_W-1:0] row_end_offset;
    logic             row_nonempty;
    logic [IDX_W-1:0] row_slot;
    logic             matrix_done;

    modport source (
        output valid, output has_index, output column_index, output row_done,
        output row_index, output row_count, output row_end_offset,
        output row_nonempty, output row_slot, output matrix_done,
        input  ready
    );
    modport sink (
        input  valid, input has_index, input column_index, input row_done,
        input  row_index, input row_count, input row_end_offset,
        input  row_nonempty, input row_slot, input matrix_done,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/mask_to_csr_converter.sv
`default_nettype none

// Channel   Dir   Payload                                  Handshake
// -------   ---   --------------------------------------   -----------
// mask      in    mask_value (8b)                          valid/ready
// result    out   has_index, column_index, row_done,       valid/ready
//                 row_index, row_count, row_end_offset,
//                 row_nonempty, row_slot, matrix_done
// cfg       in    cfg_index (row_length/row_total), data   cfg_we only
//
// One mask byte per cycle, unless a result stall holds the input register.
// Bytes pass the input register; transactions are held in the result register.
// Zero bytes that do not end a row update the counters only, with no transaction.
// A result stall holds the input register only while its byte would produce one.
// Reset clears the counters and loads both lengths with 4096 (clamped).

module mask_to_csr_converter #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire mtc_pkg::cfg_idx_t      cfg_index,
    input  wire logic [mtc_pkg::REG_W-1:0] cfg_data,
    mtc_in_if.sink                      mask,
    mtc_out_if.source                   result
);
    import mtc_pkg::*;

    // Effective length limits: the register width also caps the length.
    localparam int REG_MAX = (1 << REG_W) - 1;
    localparam int KMAX    = (MAX_COLS < REG_MAX) ? MAX_COLS : REG_MAX;
    localparam int RMAX    = (MAX_ROWS < REG_MAX) ? MAX_ROWS : REG_MAX;
    localparam int CW      = (KMAX > 1) ? $clog2(KMAX) : 1;
    localparam int RW      = (RMAX > 1) ? $clog2(RMAX) : 1;
    localparam int NZW     = $clog2(KMAX + 1);
    localparam int KRST    = ((MAX_COLS < 4096) ? MAX_COLS : 4096) - 1;
    localparam int RRST    = ((MAX_ROWS < 4096) ? MAX_ROWS : 4096) - 1;
    localparam int WIDE_W  = 17;

    // Last column / last row index, derived from each configured length.
    logic [CW-1:0]    klast_reg, klast_next;
    logic [RW-1:0]    rlast_reg, rlast_next;

    // Input register.
    logic              s1_valid_reg;
    logic [MASK_W-1:0] s1_mask_reg;

    // Running counters.
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [NZW-1:0]   nz_reg, nz_next;
    logic [OFS_W-1:0] ofs_reg, ofs_next;
    logic [IDX_W-1:0] ner_reg, ner_next;

    // Result register.
    logic             out_valid_reg;
    result_t          res_reg, res_next;

    logic             kept;
    logic             ends_row;
    logic             last_row;
    logic             nonempty;
    logic             produce;
    logic             process;
    logic [NZW-1:0]   nz_cur;
    logic [OFS_W-1:0] ofs_cur;
    logic [WIDE_W-1:0] cfg_wide;

    // Clamp a written length to [1, max] and keep its last index.
    always_comb
    begin
        cfg_wide   = WIDE_W'(cfg_data);
        klast_next = klast_reg;
        rlast_next = rlast_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROW_LENGTH:
                begin
                    if (cfg_data == '0)
                        klast_next = '0;
                    else if (cfg_wide > WIDE_W'(MAX_COLS))
                        klast_next = CW'(MAX_COLS - 1);
                    else
                        klast_next = CW'(cfg_data - REG_W'(1));
                end
                CFG_ROW_TOTAL:
                begin
                    if (cfg_data == '0)
                        rlast_next = '0;
                    else if (cfg_wide > WIDE_W'(MAX_ROWS))
                        rlast_next = RW'(MAX_ROWS - 1);
                    else
                        rlast_next = RW'(cfg_data - REG_W'(1));
                end
                default:
                begin
                    klast_next = klast_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        kept     = (s1_mask_reg != '0);
        ends_row = (col_reg >= klast_reg);
        last_row = (row_reg >= rlast_reg);
        nz_cur   = nz_reg + NZW'(kept);
        ofs_cur  = ofs_reg + OFS_W'(nz_cur);
        nonempty = (nz_cur != '0);
        produce  = kept || ends_row;
        // Advance the input register unless its transaction cannot be placed.
        process  = s1_valid_reg && (!produce || !out_valid_reg || result.ready);
    end

    assign mask.ready = !s1_valid_reg || process;

    // Counter update and result assembly for the byte in the input register.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        nz_next  = nz_reg;
        ofs_next = ofs_reg;
        ner_next = ner_reg;

        res_next                = '0;
        res_next.has_index      = kept;
        res_next.column_index   = kept ? IDX_W'(col_reg) : '0;

        if (ends_row)
        begin
            res_next.row_done       = 1'b1;
            res_next.row_index      = IDX_W'(row_reg);
            res_next.row_count      = CNT_W'(nz_cur);
            res_next.row_end_offset = ofs_cur;
            res_next.row_nonempty   = nonempty;
            res_next.row_slot       = nonempty ? ner_reg : '0;
            res_next.matrix_done    = last_row;
        end

        if (process)
        begin
            if (ends_row)
            begin
                if (last_row)
                begin
                    // Drop everything back to the start of a matrix.
                    col_next = '0;
                    row_next = '0;
                    nz_next  = '0;
                    ofs_next = '0;
                    ner_next = '0;
                end
                else
                begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                    nz_next  = '0;
                    ofs_next = ofs_cur;
                    ner_next = ner_reg + IDX_W'(nonempty);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
                nz_next  = nz_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            klast_reg     <= CW'(KRST);
            rlast_reg     <= RW'(RRST);
            s1_valid_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            nz_reg        <= '0;
            ofs_reg       <= '0;
            ner_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            klast_reg <= klast_next;
            rlast_reg <= rlast_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            nz_reg    <= nz_next;
            ofs_reg   <= ofs_next;
            ner_reg   <= ner_next;

            if (mask.ready)
                s1_valid_reg <= mask.valid;

            if (process && produce)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (mask.valid && mask.ready)
            s1_mask_reg <= mask.mask_value;
        if (process && produce)
            res_reg <= res_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.has_index      = res_reg.has_index;
    assign result.column_index   = res_reg.column_index;
    assign result.row_done       = res_reg.row_done;
    assign result.row_index      = res_reg.row_index;
    assign result.row_count      = res_reg.row_count;
    assign result.row_end_offset = res_reg.row_end_offset;
    assign result.row_nonempty   = res_reg.row_nonempty;
    assign result.row_slot       = res_reg.row_slot;
    assign result.matrix_done    = res_reg.matrix_done;

`ifndef NO_ASSERTIONS
    // A held byte keeps its value until it is processed.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !process |=> s1_valid_reg && $stable(s1_mask_reg))
        else $error("input register lost or changed a pending byte");

    // Every transaction carries a column or a row report.
    a_out_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.has_index || res_reg.row_done))
        else $error("empty transaction on result channel");

    // The end of a matrix returns all counters to zero.
    a_matrix_clear: assert property (@(posedge clk) disable iff (!rst_n)
        process && ends_row && last_row |=>
            (col_reg == '0) && (row_reg == '0) && (nz_reg == '0) &&
            (ofs_reg == '0) && (ner_reg == '0))
        else $error("counters not cleared after last row");

    // Empty rows report no slot.
    a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.row_nonempty |-> (res_reg.row_slot == '0))
        else $error("slot reported for empty row");
`endif

endmodule

`default_nettype wire
